[sv/sam_pkg.sv]
// Shared types and constants of the saturating audio mixer.
`timescale 1ns / 1ps
package sam_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SOURCES  = 4;
	localparam int LEVEL_W  = 6;
	localparam int CNT_W    = 3;
	localparam int SUM_W    = SAMPLE_W + 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [LEVEL_W-1:0]  level_t;
	typedef logic        [1:0]          action_t;
	typedef logic        [CNT_W-1:0]    count_t;

	localparam action_t ACT_MIX    = 2'd0;
	localparam action_t ACT_VOL_DN = 2'd1;
	localparam action_t ACT_VOL_UP = 2'd2;

	localparam level_t  LEVEL_MAX  = 6'd32;
	localparam count_t  SOURCES_C  = 3'(SOURCES);

	localparam logic signed [SUM_W-1:0] SAT_MAX = 18'sh07FFF;
	localparam logic signed [SUM_W-1:0] SAT_MIN = -18'sh08000;

endpackage

[sv/sam_level.sv]
// Attenuation level register stepped by volume transactions.
`timescale 1ns / 1ps
module sam_level (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  sam_pkg::action_t action,
	output sam_pkg::level_t  level
);
	import sam_pkg::*;

	level_t level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (accept) begin
			if (action == ACT_VOL_DN && level_q != '0) begin
				level_q <= level_q - 6'd1;
			end else if (action == ACT_VOL_UP && level_q < LEVEL_MAX) begin
				level_q <= level_q + 6'd1;
			end
		end
	end

	assign level = level_q;

endmodule

[sv/sam_mix_stage.sv]
// Input register, summing, saturation and attenuation, and the result register.
`timescale 1ns / 1ps
module sam_mix_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sam_pkg::SOURCES*sam_pkg::SAMPLE_W-1:0] in_samples,
	input  sam_pkg::action_t              action,
	input  sam_pkg::count_t               active_sources,
	input  sam_pkg::level_t               level,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sam_pkg::sample_t              out_sample,
	output logic                          out_clipped
);
	import sam_pkg::*;

	logic                  valid_s1;
	sample_t               sample_s1 [SOURCES];
	logic [SOURCES-1:0]    en_s1;
	level_t                level_s1;

	logic                  adv_out;
	count_t                n_src;
	logic signed [SUM_W-1:0] sum;
	sample_t               sat;
	logic                  clip;
	logic [4:0]            shamt;
	logic [LEVEL_W:0]      level_p1;
	sample_t               shifted;
	logic signed [SAMPLE_W:0] adjusted;
	sample_t               result;

	assign adv_out  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || adv_out;
	assign n_src    = (active_sources > SOURCES_C) ? SOURCES_C : active_sources;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && action == ACT_MIX && n_src != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int i = 0; i < SOURCES; i++) begin
				sample_s1[i] <= in_samples[i*SAMPLE_W +: SAMPLE_W];
				en_s1[i]     <= (CNT_W+1)'(i) < {1'b0, n_src};
			end
			level_s1 <= level;
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < SOURCES; i++) begin
			if (en_s1[i]) begin
				sum = sum + SUM_W'(sample_s1[i]);
			end
		end
		if (sum > SAT_MAX) begin
			sat  = SAMPLE_W'(SAT_MAX);
			clip = 1'b1;
		end else if (sum < SAT_MIN) begin
			sat  = SAMPLE_W'(SAT_MIN);
			clip = 1'b1;
		end else begin
			sat  = sum[SAMPLE_W-1:0];
			clip = 1'b0;
		end
		level_p1 = {1'b0, level_s1} + 7'd1;
		shamt    = level_p1[5:1];
		shifted  = sat >>> shamt;
		if (level_s1[0]) begin
			adjusted = (SAMPLE_W+1)'(shifted) + (SAMPLE_W+1)'(shifted >>> 1);
		end else begin
			adjusted = (SAMPLE_W+1)'(shifted);
		end
		result = adjusted[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_out) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			out_sample  <= result;
			out_clipped <= clip;
		end
	end

endmodule

[sv/saturating_audio_mixer_attenuator_core.sv]
// Top level of the saturating audio mixer with stepped attenuation.
// A mix transaction passes through the input register and then the result register before its result is given.
// Throughput: one transaction per cycle while m_tready does not hold the output, set by the single-pass datapath.
// Volume transactions take effect for the next accepted transaction and give no result.
// Reset clears the attenuation level to full volume and sets one active source.
`timescale 1ns / 1ps
module saturating_audio_mixer_attenuator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // sample_0, sample_1, sample_2, sample_3
	input  logic [1:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // mixed_sample
	output logic        m_tuser,   // clipped
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata  // active_sources
);
	import sam_pkg::*;

	count_t  active_q;
	level_t  level;
	sample_t mixed;
	logic    s_accept;

	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 3'd1;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	sam_level u_level (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (s_accept),
		.action (s_tuser),
		.level  (level)
	);

	sam_mix_stage u_mix (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_samples     (s_tdata[SOURCES*SAMPLE_W-1:0]),
		.action         (s_tuser),
		.active_sources (active_q),
		.level          (level),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_sample     (mixed),
		.out_clipped    (m_tuser)
	);

	assign m_tdata = mixed;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LEVEL_MAX)
		else $error("attenuation level beyond its ceiling");

	a_vol_up: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_tuser == ACT_VOL_UP && level < LEVEL_MAX |=> level == $past(level) + 6'd1)
		else $error("volume up transaction did not raise the level");

	a_mix_keeps_level: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && s_tuser != ACT_VOL_UP && s_tuser != ACT_VOL_DN |=> $stable(level))
		else $error("level changed on a transaction that is not a volume step");

endmodule

[tb/mixer_scoreboard.sv]
// Scoreboard that predicts and checks every result of the saturating audio mixer.
`timescale 1ns / 1ps
module mixer_scoreboard
	import sam_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // sample_0, sample_1, sample_2, sample_3
	input  logic [1:0]  s_tuser,   // action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // mixed_sample
	input  logic        m_tuser,   // clipped
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata, // active_sources
	output int          errors,
	output int          outstanding
);

	typedef struct packed {
		sample_t mixed;
		logic    clipped;
	} mix_result_t;

	level_t      atten_level    = '0;
	count_t      active_sources = count_t'(1);
	mix_result_t expected_mixes[$];

	initial errors = 0;
	initial outstanding = 0;

	function automatic mix_result_t mix_frame(input logic [63:0] frame, input count_t n_active,
			input level_t lvl);
		int n;
		int acc;
		mix_result_t r;
		n = (n_active > SOURCES_C) ? SOURCES : int'(n_active);
		acc = 0;
		for (int i = 0; i < n; i++) begin
			acc = acc + sample_t'(frame[SAMPLE_W*i +: SAMPLE_W]);
		end
		r.clipped = 1'b0;
		if (acc > SAT_MAX) begin
			acc = int'(SAT_MAX);
			r.clipped = 1'b1;
		end else if (acc < SAT_MIN) begin
			acc = int'(SAT_MIN);
			r.clipped = 1'b1;
		end
		if (lvl != 0) begin
			acc = acc >>> ((int'(lvl) + 1) >> 1);
		end
		if (lvl[0]) begin
			acc = acc + (acc >>> 1);
		end
		r.mixed = sample_t'(acc);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mix_result_t want;
		if (!arst_n) begin
			atten_level = '0;
			active_sources = count_t'(1);
			expected_mixes.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				active_sources = cfg_wdata;
			end
			if (m_tvalid && m_tready) begin
				if (expected_mixes.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual mixed_sample %0d clipped %0b",
						$time, $signed(m_tdata), m_tuser);
				end else begin
					want = expected_mixes.pop_front();
					if (m_tdata !== want.mixed) begin
						errors++;
						$display("%0t: mixed_sample expected %0d actual %0d",
							$time, want.mixed, $signed(m_tdata));
					end
					if (m_tuser !== want.clipped) begin
						errors++;
						$display("%0t: clipped expected %0b actual %0b",
							$time, want.clipped, m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (action_t'(s_tuser))
					ACT_MIX: begin
						if (active_sources != 0) begin
							expected_mixes.push_back(mix_frame(s_tdata, active_sources, atten_level));
						end
					end
					ACT_VOL_DN: begin
						if (atten_level != 0) begin
							atten_level = atten_level - 6'd1;
						end
					end
					ACT_VOL_UP: begin
						if (atten_level < LEVEL_MAX) begin
							atten_level = atten_level + 6'd1;
						end
					end
					default: begin
					end
				endcase
			end
			outstanding <= expected_mixes.size();
		end
	end

endmodule

[tb/tb_saturating_audio_mixer_attenuator_core.sv]
// Stimulus, flow control and verdict for the saturating audio mixer core.
`timescale 1ns / 1ps
module tb_saturating_audio_mixer_attenuator_core;
	import sam_pkg::*;

	localparam action_t ACT_UNUSED     = 2'd3;
	localparam int      DRAIN_CYCLES   = 6;
	localparam int      WATCHDOG_LIMIT = 1000;
	localparam int      PHASES         = 10;
	localparam int      PHASE_ITEMS    = 50;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_wdata = '0;

	int          errors;
	int          pending;
	int          burst_left  = 1;
	int          idle_cycles = 0;
	int          ready_mode  = 0;
	int          ready_left  = 0;
	logic [7:0]  ready_mask  = 8'hFF;

	saturating_audio_mixer_attenuator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	mixer_scoreboard scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.outstanding (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= $urandom_range(0, 2);
			ready_left <= $urandom_range(16, 96);
			ready_mask <= 8'($urandom) | 8'h01;
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ready_mask[ready_left[2:0]];
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 4))
			0: return sample_t'(16'h7FFF);
			1: return sample_t'(16'h8000);
			2: return sample_t'(int'($urandom_range(0, 64)) - 32);
			3: return $urandom_range(0, 1) ? sample_t'($urandom_range(20000, 32767))
				: sample_t'(-int'($urandom_range(20000, 32768)));
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic action_t rand_action(input int kind);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			return ACT_UNUSED;
		end
		case (kind)
			1: return (r < 50) ? ACT_VOL_UP : (r < 55) ? ACT_VOL_DN : ACT_MIX;
			2: return (r < 50) ? ACT_VOL_DN : (r < 55) ? ACT_VOL_UP : ACT_MIX;
			default: return (r < 15) ? ACT_VOL_UP : (r < 25) ? ACT_VOL_DN : ACT_MIX;
		endcase
	endfunction

	task automatic send(input action_t act, input sample_t s0, input sample_t s1,
			input sample_t s2, input sample_t s3);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {s3, s2, s1, s0};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic send_volume(input action_t act);
		send(act, rand_sample(), rand_sample(), rand_sample(), rand_sample());
	endtask

	// Stops the stimulus, waits until the scoreboard has no expected result
	// pending, and then waits the extra drain cycles.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_sources(input count_t n);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		count_t phase_sources[PHASES] = '{3'd4, 3'd1, 3'd0, 3'd2, 3'd7, 3'd3, 3'd4, 3'd5, 3'd1, 3'd4};
		int     phase_kind[PHASES]    = '{0, 1, 1, 0, 2, 2, 1, 1, 0, 2};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(ACT_MIX, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
		send(ACT_MIX, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_volume(ACT_UNUSED);
		send_volume(ACT_VOL_DN);
		set_sources(3'd4);
		send(ACT_MIX, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send(ACT_MIX, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send(ACT_MIX, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000);
		send(ACT_MIX, 16'sh7FFF, 16'sh0001, 16'sh0000, 16'sh0000);
		send(ACT_MIX, 16'sh8000, 16'shFFFF, 16'sh0000, 16'sh0000);
		send(ACT_MIX, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000);
		send(ACT_MIX, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
		send_volume(ACT_VOL_UP);
		send(ACT_MIX, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000);
		send(ACT_MIX, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000);
		send_volume(ACT_VOL_UP);
		send(ACT_MIX, 16'shFFFF, 16'sh0000, 16'sh0000, 16'sh0000);
		send_volume(ACT_VOL_DN);
		send_volume(ACT_VOL_DN);
		send_volume(ACT_VOL_DN);
		set_sources(3'd0);
		send(ACT_MIX, 16'sh1234, 16'sh5678, 16'sh0000, 16'sh0000);
		set_sources(3'd7);
		send(ACT_MIX, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send(ACT_MIX, 16'sh8000, 16'sh7FFF, 16'sh0001, 16'sh8000);

		// Climbing phases in pairs take the level up to its ceiling.
		for (int p = 0; p < PHASES; p++) begin
			set_sources(phase_sources[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send(rand_action(phase_kind[p]), rand_sample(), rand_sample(), rand_sample(),
					rand_sample());
			end
		end

		wait_idle();
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[sim.f]
sv/sam_pkg.sv
sv/sam_level.sv
sv/sam_mix_stage.sv
sv/saturating_audio_mixer_attenuator_core.sv
tb/mixer_scoreboard.sv
tb/tb_saturating_audio_mixer_attenuator_core.sv
